### design/stunap_pkg.sv
`default_nettype none
package stunap_pkg;

    // Receive buffer size; bytes beyond it are dropped
    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int IDX_W             = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [IDX_W-1:0] MAX_IDX    = IDX_W'(MAX_MESSAGE_BYTES);
    localparam logic [IDX_W-1:0] HDR_LAST   = IDX_W'(19);
    localparam logic [16:0]      HDR_BYTES  = 17'd20;

    localparam logic [31:0] STUN_COOKIE    = 32'h2112A442;
    localparam logic [15:0] TYPE_ALLOC_OK  = 16'h0103;
    localparam logic [15:0] ATTR_ERROR     = 16'h0009;
    localparam logic [15:0] ATTR_LIFE      = 16'h000D;
    localparam logic [15:0] ATTR_RELAY     = 16'h0016;
    localparam logic [15:0] ATTR_MAPPED    = 16'h0020;
    localparam logic [7:0]  FAMILY_V4      = 8'h01;
    localparam logic [9:0]  ERR_CLASS_MULT = 10'd100;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'b0001,
        PH_ATTR_HDR = 4'b0010,
        PH_VALUE    = 4'b0100,
        PH_STOP     = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [15:0] message_type;
        logic        error_present;
        logic [9:0]  error_code;
        logic        relay_found;
        logic [31:0] relay_addr;
        logic [15:0] relay_udp_port;
        logic        mapped_found;
        logic [31:0] mapped_addr;
        logic [15:0] mapped_udp_port;
        logic        lifetime_found;
        logic [31:0] lifetime_secs;
        logic        allocate_ok;
    } result_t;

endpackage
`default_nettype wire

### design/stun_allocate_response_parser_unit.sv
`default_nettype none
// STUN/TURN allocate response parser.
// Input channel (in_valid/in_ready): one message byte per transfer, with
// last_byte set on the final byte of the datagram.
// Output channel (out_valid/out_ready): one summary per datagram, issued for
// the transfer that carries last_byte; no output for any other byte.
// Throughput: one byte per cycle, except while a last byte waits for the
// output register. Each byte lands in an input register and is parsed
// from there against the running header/attribute state; the summary is
// registered, so out_valid rises once the last byte has left the input register.
// A stalled summary holds the output register; bytes of the next datagram
// keep flowing until a second last byte needs the output register, which
// then holds in_ready low until the pending summary transfers.
// Reset: asynchronous, active low; clears the parse state apart from the
// value byte buffer, and both valid flags. The parser also clears itself after every last byte.
// Bytes past the receive buffer size are dropped, but a last byte still
// closes the datagram.
module stun_allocate_response_parser_unit
    import stunap_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      message_type,
    output logic             error_present,
    output logic [9:0]       error_code,
    output logic             relay_found,
    output logic [31:0]      relay_addr,
    output logic [15:0]      relay_udp_port,
    output logic             mapped_found,
    output logic [31:0]      mapped_addr,
    output logic [15:0]      mapped_udp_port,
    output logic             lifetime_found,
    output logic [31:0]      lifetime_secs,
    output logic             allocate_ok
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       advance;
    logic       res_load;
    result_t    res_comb;
    result_t    res_out;

    // a byte moves on unless it closes a datagram and the summary slot is full
    assign advance       = in_valid_reg && (!last_reg || !out_valid || out_ready);
    assign in_ready      = !in_valid_reg || advance;
    assign in_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    stunap_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (data_reg),
        .last_byte   (last_reg),
        .result      (res_comb),
        .result_load (res_load)
    );

    stunap_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_load),
        .result_in  (res_comb),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_out (res_out)
    );

    assign message_type    = res_out.message_type;
    assign error_present   = res_out.error_present;
    assign error_code      = res_out.error_code;
    assign relay_found     = res_out.relay_found;
    assign relay_addr      = res_out.relay_addr;
    assign relay_udp_port  = res_out.relay_udp_port;
    assign mapped_found    = res_out.mapped_found;
    assign mapped_addr     = res_out.mapped_addr;
    assign mapped_udp_port = res_out.mapped_udp_port;
    assign lifetime_found  = res_out.lifetime_found;
    assign lifetime_secs   = res_out.lifetime_secs;
    assign allocate_ok     = res_out.allocate_ok;

endmodule
`default_nettype wire

### design/stunap_parser.sv
`default_nettype none
module stunap_parser
    import stunap_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output result_t         result,
    output logic            result_load
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      htype_reg, htype_next;
    logic [15:0]      hlen_reg, hlen_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      rtype_reg, rtype_next;
    logic [15:0]      rlen_reg, rlen_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [7:0]       val_reg [8];
    logic [7:0]       val_next [8];

    logic             err_found_reg, err_found_next;
    logic [9:0]       err_code_reg, err_code_next;
    logic             life_found_reg, life_found_next;
    logic [31:0]      life_reg, life_next;
    logic             relay_found_reg, relay_found_next;
    logic [31:0]      relay_addr_reg, relay_addr_next;
    logic [15:0]      relay_udp_port_reg, relay_udp_port_next;
    logic             mapped_found_reg, mapped_found_next;
    logic [31:0]      mapped_addr_reg, mapped_addr_next;
    logic [15:0]      mapped_udp_port_reg, mapped_udp_port_next;

    logic             take;
    logic [16:0]      end_lim;
    logic [16:0]      idx_ext;
    logic             in_body;
    logic [15:0]      rlen_full;
    logic [16:0]      pos_inc;
    logic [16:0]      padded_len;
    logic             pos_low;
    logic [7:0]       eff [8];
    logic [15:0]      mtype;

    assign take       = step && (idx_reg < MAX_IDX);
    assign end_lim    = HDR_BYTES + {1'b0, hlen_reg};
    assign idx_ext    = {{(17-IDX_W){1'b0}}, idx_reg};
    assign in_body    = idx_ext < end_lim;
    assign rlen_full  = {rlen_reg[15:8], data_byte};
    assign pos_inc    = {{(17-IDX_W){1'b0}}, pos_reg} + 17'd1;
    assign padded_len = ({1'b0, rlen_reg} + 17'd3) & ~17'd3;
    assign pos_low    = pos_reg < IDX_W'(8);

    // value bytes as they stand with the current byte merged in
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            eff[k] = (pos_low && (pos_reg[2:0] == 3'(k))) ? data_byte : val_reg[k];
        end
    end

    always_comb
    begin
        idx_next             = idx_reg;
        htype_next           = htype_reg;
        hlen_next            = hlen_reg;
        phase_next           = phase_reg;
        rtype_next           = rtype_reg;
        rlen_next            = rlen_reg;
        pos_next             = pos_reg;
        val_next             = val_reg;
        err_found_next       = err_found_reg;
        err_code_next        = err_code_reg;
        life_found_next      = life_found_reg;
        life_next            = life_reg;
        relay_found_next     = relay_found_reg;
        relay_addr_next      = relay_addr_reg;
        relay_udp_port_next  = relay_udp_port_reg;
        mapped_found_next    = mapped_found_reg;
        mapped_addr_next     = mapped_addr_reg;
        mapped_udp_port_next = mapped_udp_port_reg;

        if (take)
        begin
            idx_next = idx_reg + IDX_W'(1);
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (idx_reg == IDX_W'(0))      htype_next[15:8] = data_byte;
                    else if (idx_reg == IDX_W'(1)) htype_next[7:0]  = data_byte;
                    else if (idx_reg == IDX_W'(2)) hlen_next[15:8]  = data_byte;
                    else if (idx_reg == IDX_W'(3)) hlen_next[7:0]   = data_byte;
                    if (idx_reg == HDR_LAST)
                    begin
                        phase_next = PH_ATTR_HDR;
                        pos_next   = '0;
                    end
                end
                PH_ATTR_HDR:
                begin
                    if (in_body)
                    begin
                        if (pos_reg == IDX_W'(0))      rtype_next[15:8] = data_byte;
                        else if (pos_reg == IDX_W'(1)) rtype_next[7:0]  = data_byte;
                        else if (pos_reg == IDX_W'(2)) rlen_next[15:8]  = data_byte;
                        else                           rlen_next[7:0]   = data_byte;
                        pos_next = pos_reg + IDX_W'(1);
                        if (pos_reg == IDX_W'(3))
                        begin
                            pos_next = '0;
                            // record must fit inside the declared length
                            if (idx_ext + 17'd1 + {1'b0, rlen_full} > end_lim)
                                phase_next = PH_STOP;
                            else if (rlen_full != 16'd0)
                                phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE:
                begin
                    if (in_body)
                    begin
                        if (pos_low)
                            val_next[pos_reg[2:0]] = data_byte;
                        if (pos_inc == {1'b0, rlen_reg} && rlen_reg >= 16'd4)
                        begin
                            if (rtype_reg == ATTR_ERROR)
                            begin
                                if (!err_found_reg)
                                begin
                                    err_found_next = 1'b1;
                                    err_code_next  = 10'(eff[2][2:0]) * ERR_CLASS_MULT
                                                   + 10'(eff[3]);
                                end
                            end
                            else if (rtype_reg == ATTR_LIFE)
                            begin
                                life_found_next = 1'b1;
                                life_next       = {eff[0], eff[1], eff[2], eff[3]};
                            end
                            else if (rlen_reg >= 16'd8 && eff[1] == FAMILY_V4)
                            begin
                                if (rtype_reg == ATTR_RELAY)
                                begin
                                    relay_found_next    = 1'b1;
                                    relay_udp_port_next = {eff[2], eff[3]}
                                                        ^ STUN_COOKIE[31:16];
                                    relay_addr_next     = {eff[4], eff[5], eff[6], eff[7]}
                                                        ^ STUN_COOKIE;
                                end
                                else if (rtype_reg == ATTR_MAPPED)
                                begin
                                    mapped_found_next    = 1'b1;
                                    mapped_udp_port_next = {eff[2], eff[3]}
                                                         ^ STUN_COOKIE[31:16];
                                    mapped_addr_next     = {eff[4], eff[5], eff[6], eff[7]}
                                                         ^ STUN_COOKIE;
                                end
                            end
                        end
                        pos_next = pos_inc[IDX_W-1:0];
                        if (pos_inc >= padded_len)
                        begin
                            phase_next = PH_ATTR_HDR;
                            pos_next   = '0;
                        end
                    end
                end
                PH_STOP:
                begin
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase
        end

        mtype = (phase_next == PH_HEADER) ? 16'd0 : htype_next;

        result.message_type    = mtype;
        result.error_present   = err_found_next;
        result.error_code      = err_code_next;
        result.relay_found     = relay_found_next;
        result.relay_addr      = relay_addr_next;
        result.relay_udp_port  = relay_udp_port_next;
        result.mapped_found    = mapped_found_next;
        result.mapped_addr     = mapped_addr_next;
        result.mapped_udp_port = mapped_udp_port_next;
        result.lifetime_found  = life_found_next;
        result.lifetime_secs   = life_next;
        result.allocate_ok     = (mtype == TYPE_ALLOC_OK) && relay_found_next;

        result_load = step && last_byte;

        // end of datagram: start over for the next message
        if (result_load)
        begin
            idx_next             = '0;
            htype_next           = '0;
            hlen_next            = '0;
            phase_next           = PH_HEADER;
            rtype_next           = '0;
            rlen_next            = '0;
            pos_next             = '0;
            err_found_next       = 1'b0;
            err_code_next        = '0;
            life_found_next      = 1'b0;
            life_next            = '0;
            relay_found_next     = 1'b0;
            relay_addr_next      = '0;
            relay_udp_port_next  = '0;
            mapped_found_next    = 1'b0;
            mapped_addr_next     = '0;
            mapped_udp_port_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg             <= '0;
            htype_reg           <= '0;
            hlen_reg            <= '0;
            phase_reg           <= PH_HEADER;
            rtype_reg           <= '0;
            rlen_reg            <= '0;
            pos_reg             <= '0;
            err_found_reg       <= 1'b0;
            err_code_reg        <= '0;
            life_found_reg      <= 1'b0;
            life_reg            <= '0;
            relay_found_reg     <= 1'b0;
            relay_addr_reg      <= '0;
            relay_udp_port_reg  <= '0;
            mapped_found_reg    <= 1'b0;
            mapped_addr_reg     <= '0;
            mapped_udp_port_reg <= '0;
        end
        else
        begin
            idx_reg             <= idx_next;
            htype_reg           <= htype_next;
            hlen_reg            <= hlen_next;
            phase_reg           <= phase_next;
            rtype_reg           <= rtype_next;
            rlen_reg            <= rlen_next;
            pos_reg             <= pos_next;
            err_found_reg       <= err_found_next;
            err_code_reg        <= err_code_next;
            life_found_reg      <= life_found_next;
            life_reg            <= life_next;
            relay_found_reg     <= relay_found_next;
            relay_addr_reg      <= relay_addr_next;
            relay_udp_port_reg  <= relay_udp_port_next;
            mapped_found_reg    <= mapped_found_next;
            mapped_addr_reg     <= mapped_addr_next;
            mapped_udp_port_reg <= mapped_udp_port_next;
        end
    end

    // value bytes are payload only
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= MAX_IDX)
        else $error("byte index beyond receive buffer");

    a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ATTR_HDR |-> pos_reg < IDX_W'(4))
        else $error("attribute header position out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> idx_reg == '0 && phase_reg == PH_HEADER && !relay_found_reg)
        else $error("parser state not cleared after last byte");
`endif

endmodule
`default_nettype wire

### design/stunap_result_reg.sv
`default_nettype none
module stunap_result_reg
    import stunap_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result_in,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      result_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = res_reg;

`ifndef SYNTHESIS
    a_alloc_needs_relay: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.allocate_ok |-> res_reg.relay_found)
        else $error("allocate_ok without relay address");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_reg.error_present |-> res_reg.error_code == 10'd0)
        else $error("error code set without error attribute");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || out_ready)
        else $error("result overwritten before transfer");
`endif

endmodule
`default_nettype wire
